@@ rtl/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define ASSERT_IMPL(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

@@ rtl/ffba_pkg.sv @@
// Types and constants of the first-fit block allocator.
package ffba_pkg;

	localparam int unsigned HEADER_BYTES = 32;
	localparam int unsigned MIN_PAYLOAD  = 32;
	localparam int unsigned ALIGN_BYTES  = 8;
	localparam int unsigned IDX_W        = 10;

	localparam logic [1:0] MODE_FORMAT  = 2'd0;
	localparam logic [1:0] MODE_ALLOC   = 2'd1;
	localparam logic [1:0] MODE_RELEASE = 2'd2;
	localparam logic [1:0] MODE_QUERY   = 2'd3;

	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NOT_FMT     = 3'd1;
	localparam logic [2:0] ST_ZERO_SIZE   = 3'd2;
	localparam logic [2:0] ST_NO_FIT      = 3'd3;
	localparam logic [2:0] ST_BAD_ADDR    = 3'd4;
	localparam logic [2:0] ST_DOUBLE_FREE = 3'd5;
	localparam logic [2:0] ST_POOL_SMALL  = 3'd6;

	localparam logic REG_BASE = 1'b0;
	localparam logic REG_POOL = 1'b1;

	typedef struct packed {
		logic [31:0] offset;
		logic [31:0] size;
		logic        free;
	} seg_t;

	typedef enum logic [2:0] {
		OP_PASS    = 3'd0,
		OP_FORMAT  = 3'd1,
		OP_TAKE    = 3'd2,
		OP_SPLIT   = 3'd3,
		OP_RELEASE = 3'd4
	} op_t;

	typedef struct packed {
		op_t              op;
		logic [IDX_W-1:0] j;
		logic [IDX_W-1:0] k;
		logic             pm;
		logic             nm;
	} head_ctrl_t;

endpackage

@@ rtl/first_fit_block_allocator_top.sv @@
// First-fit block allocator: sequencer, bookkeeping and the ring of segment cells.
// Each request is accepted in a beat; allocate and release then run a search rotation
// of the ring, one cell a cycle, a decide step and a rewrite rotation of the ring; format
// runs only the rewrite rotation, a failed search ends after the decide step, and query
// or early rejected requests go straight to the finish step, which registers the result.
// The finish step waits for a free output, and only then is a new request taken.
module first_fit_block_allocator_top #(
	parameter int unsigned MAX_SEGMENTS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [47:0] cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  mode,
	input  logic [31:0] request_bytes,
	input  logic [47:0] block_address,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [2:0]  status,
	output logic [47:0] payload_address,
	output logic [31:0] total_bytes,
	output logic [31:0] used_bytes,
	output logic [31:0] free_bytes,
	output logic [6:0]  used_segments
);

	// Reset clears control state and totals; the segment cells are not cleared.

	localparam int unsigned IW = $clog2(MAX_SEGMENTS);
	localparam int unsigned CW = $clog2(MAX_SEGMENTS + 1);
	localparam logic [IW-1:0] J_LAST = IW'(MAX_SEGMENTS - 1);
	localparam logic [32:0] ALIGN_MASK = 33'(ffba_pkg::ALIGN_BYTES - 1);

	typedef enum logic [4:0] {
		S_IDLE   = 5'b00001,
		S_SEARCH = 5'b00010,
		S_DECIDE = 5'b00100,
		S_MODIFY = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q;

	logic [47:0] base_q;
	logic [31:0] pool_q;
	logic [47:0] pool_base_q;
	logic [31:0] recorded_q;
	logic [31:0] used_total_q;
	logic [CW-1:0] used_count_q;
	logic [CW-1:0] count_q;
	logic        formatted_q;

	logic [1:0]  mode_q;
	logic [32:0] want_q;
	logic [47:0] addr_q;
	logic [IW-1:0] j_q;
	logic [IW-1:0] k_q;
	logic        found_q;
	logic [31:0] sk_q;
	logic [31:0] offk_q;
	logic        freek_q;
	logic        pm_q;
	logic        nm_q;
	logic [31:0] ps_q;
	logic [31:0] part_q;
	ffba_pkg::op_t op_q;
	ffba_pkg::seg_t new_q;
	ffba_pkg::seg_t buf_q;
	logic [2:0]  st_q;
	logic [47:0] res_addr_q;

	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [47:0] out_addr_q;
	logic [31:0] out_total_q;
	logic [31:0] out_used_q;
	logic [31:0] out_free_q;
	logic [6:0]  out_segs_q;

	ffba_pkg::seg_t cell_q [MAX_SEGMENTS];
	ffba_pkg::seg_t emit;
	ffba_pkg::head_ctrl_t hctrl;
	logic        shift_en;

	logic        in_beat;
	logic        hit;
	logic        j_valid;
	logic [CW:0] j_next;
	logic        split;
	logic [32:0] want_c;

	assign in_ready = (state_q == S_IDLE);
	assign in_beat  = in_valid && in_ready;
	assign shift_en = (state_q == S_SEARCH) || (state_q == S_MODIFY);

	// Ring of cells: each one takes its right neighbor, the last one takes the head output.
	for (genvar i = 0; i < MAX_SEGMENTS; i++) begin : g_cell
		ffba_pkg::seg_t d;
		if (i == MAX_SEGMENTS - 1) begin : g_tail
			assign d = emit;
		end else begin : g_mid
			assign d = cell_q[i+1];
		end
		ffba_cell u_cell (
			.clk      (clk),
			.shift_en (shift_en),
			.d        (d),
			.q        (cell_q[i])
		);
	end

	always_comb begin
		hctrl.op = (state_q == S_MODIFY) ? op_q : ffba_pkg::OP_PASS;
		hctrl.j  = ffba_pkg::IDX_W'(j_q);
		hctrl.k  = ffba_pkg::IDX_W'(k_q);
		hctrl.pm = pm_q;
		hctrl.nm = nm_q;
	end

	ffba_head u_head (
		.ctrl    (hctrl),
		.prv     (buf_q),
		.cur     (cell_q[0]),
		.nxt     (cell_q[1 % MAX_SEGMENTS]),
		.nxt2    (cell_q[2 % MAX_SEGMENTS]),
		.new_seg (new_q),
		.want_lo (want_q[31:0]),
		.emit    (emit)
	);

	always_comb begin
		want_c  = ({1'b0, request_bytes} + ALIGN_MASK) & ~ALIGN_MASK;
		j_valid = {1'b0, j_q} < (CW+1)'(count_q);
		j_next  = (CW+1)'(j_q) + 1'b1;
		if (mode_q == ffba_pkg::MODE_ALLOC) begin
			hit = cell_q[0].free && ({1'b0, cell_q[0].size} >= want_q);
		end else begin
			hit = (pool_base_q + {16'b0, cell_q[0].offset} + 48'(ffba_pkg::HEADER_BYTES))
				== addr_q;
		end
		hit   = hit && j_valid && !found_q;
		split = ({2'b0, sk_q} >= ({1'b0, want_q} +
			34'(ffba_pkg::HEADER_BYTES + ffba_pkg::MIN_PAYLOAD)))
			&& (count_q < CW'(MAX_SEGMENTS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			pool_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ffba_pkg::REG_BASE: base_q <= cfg_data;
				ffba_pkg::REG_POOL: pool_q <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (shift_en) begin
			buf_q <= cell_q[0];
		end
		if (in_beat) begin
			mode_q <= mode;
			want_q <= want_c;
			addr_q <= block_address;
		end
		if (state_q == S_SEARCH && hit) begin
			k_q     <= j_q;
			sk_q    <= cell_q[0].size;
			offk_q  <= cell_q[0].offset;
			freek_q <= cell_q[0].free;
			ps_q    <= buf_q.size;
			pm_q    <= (j_q != '0) && buf_q.free;
			nm_q    <= (j_next < (CW+1)'(count_q)) && cell_q[1 % MAX_SEGMENTS].free;
			part_q  <= cell_q[0].size + (((j_next < (CW+1)'(count_q)) &&
				cell_q[1 % MAX_SEGMENTS].free) ?
				(cell_q[1 % MAX_SEGMENTS].size + 32'(ffba_pkg::HEADER_BYTES)) : 32'd0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			j_q          <= '0;
			found_q      <= 1'b0;
			op_q         <= ffba_pkg::OP_PASS;
			pool_base_q  <= '0;
			recorded_q   <= '0;
			used_total_q <= '0;
			used_count_q <= '0;
			count_q      <= '0;
			formatted_q  <= 1'b0;
			st_q         <= ffba_pkg::ST_OK;
			res_addr_q   <= '0;
			new_q        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= '0;
			out_addr_q   <= '0;
			out_total_q  <= '0;
			out_used_q   <= '0;
			out_free_q   <= '0;
			out_segs_q   <= '0;
		end else begin
			if (out_valid_q && out_ready && state_q != S_FINISH) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_beat) begin
						j_q        <= '0;
						found_q    <= 1'b0;
						res_addr_q <= '0;
						case (mode)
							ffba_pkg::MODE_FORMAT: begin
								if (base_q == '0 || pool_q <
									32'(ffba_pkg::HEADER_BYTES + ffba_pkg::MIN_PAYLOAD)) begin
									st_q    <= ffba_pkg::ST_POOL_SMALL;
									state_q <= S_FINISH;
								end else begin
									st_q         <= ffba_pkg::ST_OK;
									pool_base_q  <= base_q;
									recorded_q   <= pool_q;
									used_total_q <= '0;
									used_count_q <= '0;
									count_q      <= CW'(1);
									formatted_q  <= 1'b1;
									new_q.offset <= '0;
									new_q.size   <= pool_q - 32'(ffba_pkg::HEADER_BYTES);
									new_q.free   <= 1'b1;
									op_q         <= ffba_pkg::OP_FORMAT;
									state_q      <= S_MODIFY;
								end
							end
							ffba_pkg::MODE_ALLOC: begin
								if (!formatted_q) begin
									st_q    <= ffba_pkg::ST_NOT_FMT;
									state_q <= S_FINISH;
								end else if (request_bytes == '0) begin
									st_q    <= ffba_pkg::ST_ZERO_SIZE;
									state_q <= S_FINISH;
								end else begin
									st_q    <= ffba_pkg::ST_OK;
									state_q <= S_SEARCH;
								end
							end
							ffba_pkg::MODE_RELEASE: begin
								if (!formatted_q) begin
									st_q    <= ffba_pkg::ST_NOT_FMT;
									state_q <= S_FINISH;
								end else begin
									st_q    <= ffba_pkg::ST_OK;
									state_q <= S_SEARCH;
								end
							end
							default: begin
								st_q    <= formatted_q ? ffba_pkg::ST_OK : ffba_pkg::ST_NOT_FMT;
								state_q <= S_FINISH;
							end
						endcase
					end
				end
				S_SEARCH: begin
					if (hit) begin
						found_q <= 1'b1;
					end
					if (j_q == J_LAST) begin
						j_q     <= '0;
						state_q <= S_DECIDE;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_DECIDE: begin
					if (mode_q == ffba_pkg::MODE_ALLOC) begin
						if (!found_q) begin
							st_q    <= ffba_pkg::ST_NO_FIT;
							state_q <= S_FINISH;
						end else begin
							new_q.offset <= offk_q + want_q[31:0] +
								32'(ffba_pkg::HEADER_BYTES);
							new_q.size   <= sk_q - want_q[31:0] -
								32'(ffba_pkg::HEADER_BYTES);
							new_q.free   <= 1'b1;
							op_q         <= split ? ffba_pkg::OP_SPLIT : ffba_pkg::OP_TAKE;
							used_total_q <= used_total_q + (split ? want_q[31:0] : sk_q);
							used_count_q <= used_count_q + 1'b1;
							if (split) begin
								count_q <= count_q + 1'b1;
							end
							res_addr_q <= pool_base_q + {16'b0, offk_q} +
								48'(ffba_pkg::HEADER_BYTES);
							state_q    <= S_MODIFY;
						end
					end else begin
						if (!found_q) begin
							st_q    <= ffba_pkg::ST_BAD_ADDR;
							state_q <= S_FINISH;
						end else if (freek_q) begin
							st_q    <= ffba_pkg::ST_DOUBLE_FREE;
							state_q <= S_FINISH;
						end else begin
							new_q.size   <= part_q + (pm_q ?
								(ps_q + 32'(ffba_pkg::HEADER_BYTES)) : 32'd0);
							op_q         <= ffba_pkg::OP_RELEASE;
							used_total_q <= used_total_q - sk_q;
							used_count_q <= used_count_q - 1'b1;
							count_q      <= count_q - CW'(pm_q) - CW'(nm_q);
							state_q      <= S_MODIFY;
						end
					end
				end
				S_MODIFY: begin
					if (j_q == J_LAST) begin
						j_q     <= '0;
						state_q <= S_FINISH;
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_FINISH: begin
					if (!out_valid_q || out_ready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= st_q;
						out_addr_q   <= (st_q == ffba_pkg::ST_OK) ? res_addr_q : 48'd0;
						out_total_q  <= recorded_q;
						out_used_q   <= used_total_q;
						out_free_q   <= recorded_q - used_total_q -
							32'(32'(used_count_q) * ffba_pkg::HEADER_BYTES);
						out_segs_q   <= 7'(used_count_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid       = out_valid_q;
	assign status          = out_status_q;
	assign payload_address = out_addr_q;
	assign total_bytes     = out_total_q;
	assign used_bytes      = out_used_q;
	assign free_bytes      = out_free_q;
	assign used_segments   = out_segs_q;

`include "assert_macros.svh"

	`ASSERT_IMPL(a_count_bound, 1'b1, count_q <= CW'(MAX_SEGMENTS))
	`ASSERT_IMPL(a_used_le_count, 1'b1, used_count_q <= count_q)
	`ASSERT_NEXT(a_modify_end, (state_q == S_MODIFY) && (j_q == J_LAST), state_q == S_FINISH)

endmodule

@@ rtl/ffba_cell.sv @@
// One segment cell of the rotating segment table.
module ffba_cell (
	input  logic          clk,
	input  logic          shift_en,
	input  ffba_pkg::seg_t d,
	output ffba_pkg::seg_t q
);

	ffba_pkg::seg_t seg_q;

	always_ff @(posedge clk) begin
		if (shift_en) begin
			seg_q <= d;
		end
	end

	assign q = seg_q;

endmodule

@@ rtl/ffba_head.sv @@
// Head of the segment ring: rewrites the stream to insert, update or drop segments.
module ffba_head (
	input  ffba_pkg::head_ctrl_t ctrl,
	input  ffba_pkg::seg_t       prv,
	input  ffba_pkg::seg_t       cur,
	input  ffba_pkg::seg_t       nxt,
	input  ffba_pkg::seg_t       nxt2,
	input  ffba_pkg::seg_t       new_seg,
	input  logic [31:0]          want_lo,
	output ffba_pkg::seg_t       emit
);

	logic [ffba_pkg::IDX_W:0] j_x;
	logic [ffba_pkg::IDX_W:0] k_x;
	logic [ffba_pkg::IDX_W:0] b_x;

	always_comb begin
		j_x  = {1'b0, ctrl.j};
		k_x  = {1'b0, ctrl.k};
		// The first slot touched by a release is the free neighbor in front, if any.
		b_x  = ctrl.pm ? (k_x - 1'b1) : k_x;
		emit = cur;
		case (ctrl.op)
			ffba_pkg::OP_FORMAT: begin
				if (j_x == '0) begin
					emit = new_seg;
				end
			end
			ffba_pkg::OP_TAKE: begin
				if (j_x == k_x) begin
					emit.free = 1'b0;
				end
			end
			ffba_pkg::OP_SPLIT: begin
				if (j_x == k_x) begin
					emit.size = want_lo;
					emit.free = 1'b0;
				end else if (j_x == k_x + 1'b1) begin
					emit = new_seg;
				end else if (j_x > k_x + 1'b1) begin
					emit = prv;
				end
			end
			ffba_pkg::OP_RELEASE: begin
				if (j_x == b_x) begin
					if (ctrl.pm || ctrl.nm) begin
						emit.size = new_seg.size;
					end
					emit.free = 1'b1;
				end else if (j_x > b_x) begin
					case ({ctrl.pm, ctrl.nm})
						2'b00:   emit = cur;
						2'b11:   emit = nxt2;
						default: emit = nxt;
					endcase
				end
			end
			default: ;
		endcase
	end

endmodule

@@ sim/testbench.sv @@
// Self-checking testbench for the first-fit block allocator with its own allocator predictor.
module testbench;

	localparam int NSEG = 64;
	localparam int HDR = 32;
	localparam int MINP = 32;
	localparam int DRAIN_CYCLES = 300;
	localparam int CYCLE_LIMIT = 3000000;
	localparam logic [47:0] ADDR_MASK = 48'hFFFF_FFFF_FFFF;

	typedef struct {
		logic [2:0]  st;
		logic [47:0] addr;
		logic [31:0] tot;
		logic [31:0] used;
		logic [31:0] free;
		logic [6:0]  segs;
	} outcome_t;

	typedef enum {ROW_CFG, ROW_ITEM} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		logic [47:0] base;
		logic [31:0] pool;
		logic [1:0]  md;
		logic [31:0] req;
		logic [47:0] addr;
		bit          typed;
		logic [2:0]  st;
	} stim_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic        cfg_index = ffba_pkg::REG_BASE;
	logic [47:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [1:0]  mode = ffba_pkg::MODE_QUERY;
	logic [31:0] request_bytes = '0;
	logic [47:0] block_address = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [2:0]  status;
	logic [47:0] payload_address;
	logic [31:0] total_bytes;
	logic [31:0] used_bytes;
	logic [31:0] free_bytes;
	logic [6:0]  used_segments;

	first_fit_block_allocator_top dut (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Predictor state: the segment table, totals and register copies.
	logic [31:0] seg_off [NSEG];
	logic [31:0] seg_size [NSEG];
	bit          seg_free [NSEG];
	int          seg_cnt;
	bit          fmt_done;
	logic [31:0] used_tot;
	int          used_cnt;
	logic [31:0] rec_tot;
	logic [47:0] pool_base;
	logic [47:0] base_reg;
	logic [31:0] pool_reg;

	outcome_t    result_q[$];
	int          errors = 0;
	int          items_sent = 0;
	int          results_seen = 0;
	int          status_hist [8];
	longint      cycles = 0;
	bit          no_idle = 1'b0;
	int          stall_left = 0;

	function automatic int gap_len();
		int r;
		r = $urandom_range(0, 99);
		if (no_idle || r < 50)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 60);
	endfunction

	function automatic logic [47:0] payload_at(int k);
		return (pool_base + 48'(seg_off[k]) + 48'(HDR)) & ADDR_MASK;
	endfunction

	function automatic void drop_entry(int k);
		for (int j = k; j + 1 < seg_cnt; j++) begin
			seg_off[j] = seg_off[j + 1];
			seg_size[j] = seg_size[j + 1];
			seg_free[j] = seg_free[j + 1];
		end
		seg_cnt--;
	endfunction

	function automatic outcome_t allocator_predict(logic [1:0] md, logic [31:0] req,
			logic [47:0] addr);
		outcome_t o;
		longint unsigned want;
		int k;
		o.st = ffba_pkg::ST_OK;
		o.addr = '0;
		case (md)
			ffba_pkg::MODE_FORMAT: begin
				if (base_reg == 0 || pool_reg < HDR + MINP) begin
					o.st = ffba_pkg::ST_POOL_SMALL;
				end else begin
					pool_base = base_reg;
					rec_tot = pool_reg;
					used_tot = 0;
					used_cnt = 0;
					seg_cnt = 1;
					seg_off[0] = 0;
					seg_size[0] = pool_reg - HDR;
					seg_free[0] = 1'b1;
					fmt_done = 1'b1;
				end
			end
			ffba_pkg::MODE_ALLOC: begin
				if (!fmt_done) begin
					o.st = ffba_pkg::ST_NOT_FMT;
				end else if (req == 0) begin
					o.st = ffba_pkg::ST_ZERO_SIZE;
				end else begin
					want = ((longint'(req) + 7) / 8) * 8;
					for (k = 0; k < seg_cnt; k++)
						if (seg_free[k] && longint'(seg_size[k]) >= want)
							break;
					if (k >= seg_cnt) begin
						o.st = ffba_pkg::ST_NO_FIT;
					end else begin
						if (longint'(seg_size[k]) >= want + HDR + MINP && seg_cnt < NSEG) begin
							for (int j = seg_cnt; j > k + 1; j--) begin
								seg_off[j] = seg_off[j - 1];
								seg_size[j] = seg_size[j - 1];
								seg_free[j] = seg_free[j - 1];
							end
							seg_off[k + 1] = 32'(longint'(seg_off[k]) + HDR + want);
							seg_size[k + 1] = 32'(longint'(seg_size[k]) - want - HDR);
							seg_free[k + 1] = 1'b1;
							seg_size[k] = 32'(want);
							seg_cnt++;
						end
						seg_free[k] = 1'b0;
						used_cnt++;
						used_tot += seg_size[k];
						o.addr = payload_at(k);
					end
				end
			end
			ffba_pkg::MODE_RELEASE: begin
				if (!fmt_done) begin
					o.st = ffba_pkg::ST_NOT_FMT;
				end else begin
					for (k = 0; k < seg_cnt; k++)
						if (payload_at(k) == addr)
							break;
					if (k >= seg_cnt) begin
						o.st = ffba_pkg::ST_BAD_ADDR;
					end else if (seg_free[k]) begin
						o.st = ffba_pkg::ST_DOUBLE_FREE;
					end else begin
						seg_free[k] = 1'b1;
						used_cnt--;
						used_tot -= seg_size[k];
						if (k + 1 < seg_cnt && seg_free[k + 1]) begin
							seg_size[k] += HDR + seg_size[k + 1];
							drop_entry(k + 1);
						end
						if (k > 0 && seg_free[k - 1]) begin
							seg_size[k - 1] += HDR + seg_size[k];
							drop_entry(k);
						end
					end
				end
			end
			default: o.st = fmt_done ? ffba_pkg::ST_OK : ffba_pkg::ST_NOT_FMT;
		endcase
		o.tot = rec_tot;
		o.used = used_tot;
		o.free = rec_tot - used_tot - 32'(used_cnt * HDR);
		o.segs = 7'(used_cnt);
		return o;
	endfunction

	task automatic wait_drained();
		while (result_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_regs(logic [47:0] base, logic [31:0] pool);
		wait_drained();
		cfg_we <= 1'b1;
		cfg_index <= ffba_pkg::REG_BASE;
		cfg_data <= base;
		@(posedge clk);
		cfg_index <= ffba_pkg::REG_POOL;
		cfg_data <= {16'h0, pool};
		@(posedge clk);
		cfg_we <= 1'b0;
		base_reg = base;
		pool_reg = pool;
	endtask

	// Returns the prediction so a directed row can also be held to a typed status.
	task automatic send_item(logic [1:0] md, logic [31:0] req, logic [47:0] addr,
			output outcome_t o);
		int g;
		g = gap_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
		in_valid <= 1'b1;
		mode <= md;
		request_bytes <= req;
		block_address <= addr;
		do
			@(posedge clk);
		while (!in_ready);
		o = allocator_predict(md, req, addr);
		result_q.push_back(o);
		items_sent++;
	endtask

	task automatic end_burst();
		in_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic random_item();
		outcome_t o;
		logic [31:0] req;
		logic [47:0] addr;
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) begin
			req = ($urandom_range(0, 9) == 0) ? $urandom() : $urandom_range(1, 300);
			send_item(ffba_pkg::MODE_ALLOC, req, 48'h0, o);
		end else if (r < 85 && seg_cnt > 0) begin
			// Mostly live payload addresses; a free one gives a double free.
			addr = payload_at($urandom_range(0, seg_cnt - 1));
			send_item(ffba_pkg::MODE_RELEASE, $urandom(), addr, o);
		end else if (r < 92) begin
			addr = 48'({$urandom(), $urandom()});
			if ($urandom_range(0, 1))
				addr = payload_at(0) + 48'($urandom_range(1, 7));
			send_item(ffba_pkg::MODE_RELEASE, $urandom(), addr, o);
		end else if (r < 97) begin
			send_item(ffba_pkg::MODE_QUERY, $urandom(), 48'({$urandom(), $urandom()}), o);
		end else if (r < 99) begin
			send_item(ffba_pkg::MODE_ALLOC, 32'h0, 48'h0, o);
		end else begin
			send_item(ffba_pkg::MODE_FORMAT, $urandom(), 48'({$urandom(), $urandom()}), o);
		end
	endtask

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				result_q.size());
			$display("== FAIL ==");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			out_ready <= 1'b1;
			if ($urandom_range(0, 99) < 20)
				stall_left <= gap_len();
		end
	end

	always @(posedge clk) begin
		outcome_t e;
		if (arst_n && out_valid && out_ready) begin
			results_seen++;
			if (result_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result beat: status %0d", status);
			end else begin
				e = result_q.pop_front();
				status_hist[e.st]++;
				if (status !== e.st || payload_address !== e.addr || total_bytes !== e.tot ||
						used_bytes !== e.used || free_bytes !== e.free ||
						used_segments !== e.segs) begin
					errors++;
					if (errors <= 10)
						$display("mismatch: exp st %0d addr %h tot %0d used %0d free %0d segs %0d / got st %0d addr %h tot %0d used %0d free %0d segs %0d",
							e.st, e.addr, e.tot, e.used, e.free, e.segs, status,
							payload_address, total_bytes, used_bytes, free_bytes,
							used_segments);
				end
			end
		end
	end

	stim_row_t directed [] = '{
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_ALLOC, 32'd8, 0, 1, ffba_pkg::ST_NOT_FMT},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_RELEASE, 0, 48'h20, 1, ffba_pkg::ST_NOT_FMT},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_QUERY, 0, 0, 1, ffba_pkg::ST_NOT_FMT},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_FORMAT, 0, 0, 1, ffba_pkg::ST_POOL_SMALL},
		'{ROW_CFG, 48'h1000, 32'd63, ffba_pkg::MODE_FORMAT, 0, 0, 0, ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_FORMAT, 0, 0, 1, ffba_pkg::ST_POOL_SMALL},
		'{ROW_CFG, 48'h1000, 32'd64, ffba_pkg::MODE_FORMAT, 0, 0, 0, ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_FORMAT, 0, 0, 1, ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_QUERY, 0, 0, 1, ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_ALLOC, 32'd33, 0, 1, ffba_pkg::ST_NO_FIT},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_ALLOC, 32'd1, 0, 0, ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_RELEASE, 0, 48'h1020, 0, ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_RELEASE, 0, 48'h1020, 1, ffba_pkg::ST_DOUBLE_FREE},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_RELEASE, 0, 48'h1021, 1, ffba_pkg::ST_BAD_ADDR},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_ALLOC, 32'd0, 0, 1, ffba_pkg::ST_ZERO_SIZE},
		'{ROW_CFG, 48'hFFFF_FFFF_FFF0, 32'hFFFF_FFFF, ffba_pkg::MODE_FORMAT, 0, 0, 0,
			ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_FORMAT, 0, 0, 1, ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_ALLOC, 32'hFFFF_FFFF, 0, 1, ffba_pkg::ST_NO_FIT},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_ALLOC, 32'd8, 0, 0, ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_ALLOC, 32'hFFFF_FF00, 0, 0, ffba_pkg::ST_OK},
		'{ROW_CFG, 48'h0, 32'd0, ffba_pkg::MODE_FORMAT, 0, 0, 0, ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_RELEASE, 0, 48'h10, 0, ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_ALLOC, 32'd100, 0, 0, ffba_pkg::ST_OK},
		'{ROW_ITEM, 0, 0, ffba_pkg::MODE_FORMAT, 0, 0, 1, ffba_pkg::ST_POOL_SMALL}
	};

	initial begin
		outcome_t o;
		logic [47:0] base;
		logic [31:0] pool;
		seg_cnt = 0;
		fmt_done = 1'b0;
		used_tot = 0;
		used_cnt = 0;
		rec_tot = 0;
		pool_base = 0;
		base_reg = 0;
		pool_reg = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed[i]) begin
			if (directed[i].kind == ROW_CFG) begin
				end_burst();
				write_regs(directed[i].base, directed[i].pool);
			end else begin
				send_item(directed[i].md, directed[i].req, directed[i].addr, o);
				if (directed[i].typed && o.st !== directed[i].st) begin
					errors++;
					if (errors <= 10)
						$display("directed row %0d: predicted status %0d, table says %0d", i,
							o.st, directed[i].st);
				end
			end
		end
		end_burst();

		for (int ph = 0; ph < 8; ph++) begin
			no_idle = (ph == 2 || ph == 5);
			case (ph)
				0: begin base = 48'h0000_0001_0000; pool = 32'd4096; end
				1: begin base = 48'hFFFF_FFFF_FF00; pool = 32'hFFFF_FFFF; end
				3: begin base = 48'h8000_0000_0000; pool = 32'd64; end
				6: begin
					base = 48'({$urandom(), $urandom()});
					pool = $urandom_range(64, 1024);
				end
				default: begin
					base = {16'($urandom()), $urandom()} | 48'h8;
					pool = $urandom_range(64, 20000);
				end
			endcase
			write_regs(base, pool);
			send_item(ffba_pkg::MODE_FORMAT, $urandom(), 48'({$urandom(), $urandom()}), o);
			// A new base after format must not move the live pool's addresses.
			if (ph == 4) begin
				end_burst();
				write_regs(48'({$urandom(), $urandom()}), $urandom());
			end
			for (int n = 0; n < 200; n++) begin
				if (n == 100) begin
					end_burst();
					while (result_q.size() != 0)
						@(posedge clk);
				end
				random_item();
			end
			end_burst();
		end

		wait_drained();
		$display("Sent %0d requests and checked %0d results over 8 pool settings.",
			items_sent, results_seen);
		$display("By status: ok %0d, not formatted %0d, zero %0d, no fit %0d, bad %0d, double %0d, small %0d",
			status_hist[0], status_hist[1], status_hist[2], status_hist[3],
			status_hist[4], status_hist[5], status_hist[6]);
		if (errors == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches", errors);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
